/* rtl/core/preset_countdown_timer_top_defines.svh */
// Assertion macros for the preset countdown timer.
`ifndef PRESET_COUNTDOWN_TIMER_TOP_DEFINES_SVH
`define PRESET_COUNTDOWN_TIMER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pct assertion failed");

// Next-cycle implication, disabled during reset.
`define PCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pct assertion failed");

`endif

/* rtl/core/pct_pkg.sv */
// Shared types and constants of the preset countdown timer.
package pct_pkg;

    localparam int KIND_W     = 2;
    localparam int TPS_W      = 8;
    localparam int TIME_W     = 6;
    localparam int OUT_GEAR_W = 3;
    localparam int OUT_HRS_W  = 3;

    localparam int TOP_GEAR_DEFAULT = 7;

    localparam logic [TPS_W-1:0]  TICKS_RESET = 8'd100;
    localparam logic [TIME_W-1:0] SECS_MAX    = 6'd59;
    localparam logic [TIME_W-1:0] HALF_HOUR   = 6'd30;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 2'd0,
        KIND_KEY    = 2'd1,
        KIND_STATUS = 2'd2,
        KIND_OTHER  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  loads_idle;
    } t_item;

    typedef struct packed {
        logic [OUT_GEAR_W-1:0] gear;
        logic                  running;
        logic [OUT_HRS_W-1:0]  hours_left;
        logic [TIME_W-1:0]     minutes_left;
        logic [TIME_W-1:0]     seconds_left;
        logic                  expired;
        logic                  locked;
    } t_result;

endpackage

/* rtl/core/pct_if.sv */
// Input and result channel interfaces of the preset countdown timer.
interface pct_in_if;
    logic                      valid;
    logic                      ready;
    logic [pct_pkg::KIND_W-1:0] kind;
    logic                      loads_idle;

    modport source (output valid, output kind, output loads_idle, input ready);
    modport sink   (input valid, input kind, input loads_idle, output ready);
endinterface

interface pct_out_if;
    logic                          valid;
    logic                          ready;
    logic [pct_pkg::OUT_GEAR_W-1:0] gear;
    logic                          running;
    logic [pct_pkg::OUT_HRS_W-1:0]  hours_left;
    logic [pct_pkg::TIME_W-1:0]     minutes_left;
    logic [pct_pkg::TIME_W-1:0]     seconds_left;
    logic                          expired;
    logic                          locked;

    modport source (
        output valid, output gear, output running, output hours_left,
        output minutes_left, output seconds_left, output expired, output locked,
        input  ready
    );
    modport sink (
        input  valid, input gear, input running, input hours_left,
        input  minutes_left, input seconds_left, input expired, input locked,
        output ready
    );
endinterface

/* rtl/core/preset_countdown_timer_top.sv */
// Top level of the preset countdown timer: channels, input and result registers.
// An accepted item waits in the input register; its result is registered in the result register when it advances.
// Throughput: one item per cycle while the result channel is not stalled; the state update
// is combinational between the input register and the result register.
// A stalled result holds while the input register still accepts one item.
// Reset (synchronous, active low) clears the timer state and sets ticks_per_second to 100.
module preset_countdown_timer_top #(
    parameter int TOP_GEAR = pct_pkg::TOP_GEAR_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [pct_pkg::TPS_W-1:0] i_cfg_wdata,
    pct_in_if.sink                    i_in,
    pct_out_if.source                 o_out
);

    logic [pct_pkg::TPS_W-1:0] r_tps;
    logic                      r_in_valid;
    pct_pkg::t_item            r_in_item;
    logic                      r_out_valid;
    pct_pkg::t_result          r_out;
    pct_pkg::t_result          result;
    logic                      advance;
    logic                      in_take;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= pct_pkg::TICKS_RESET;
        end else if (i_cfg_we) begin
            r_tps <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item.kind       <= pct_pkg::t_kind'(i_in.kind);
            r_in_item.loads_idle <= i_in.loads_idle;
        end
    end

    pct_core #(
        .TOP_GEAR (TOP_GEAR)
    ) u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_fire             (advance),
        .i_item             (r_in_item),
        .i_ticks_per_second (r_tps),
        .o_result           (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.gear         = r_out.gear;
    assign o_out.running      = r_out.running;
    assign o_out.hours_left   = r_out.hours_left;
    assign o_out.minutes_left = r_out.minutes_left;
    assign o_out.seconds_left = r_out.seconds_left;
    assign o_out.expired      = r_out.expired;
    assign o_out.locked       = r_out.locked;

endmodule

/* rtl/core/pct_core.sv */
// Timer state registers and the per-item update logic.
module pct_core #(
    parameter int TOP_GEAR = pct_pkg::TOP_GEAR_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  pct_pkg::t_item             i_item,
    input  logic [pct_pkg::TPS_W-1:0]  i_ticks_per_second,
    output pct_pkg::t_result           o_result
);

    localparam int GW = $clog2(TOP_GEAR + 1);
    localparam logic [GW-1:0] TopGear = GW'(TOP_GEAR);

    logic [pct_pkg::TPS_W-1:0]  r_prescale, n_prescale;
    logic [pct_pkg::TIME_W-1:0] r_secs, n_secs;
    logic [pct_pkg::TIME_W-1:0] r_mins, n_mins;
    logic [GW-1:0]              r_hours, n_hours;
    logic [GW-1:0]              r_gear, n_gear;
    logic                       r_run, n_run;
    logic                       r_lock, n_lock;
    logic                       r_armed, n_armed;
    logic                       expired;
    logic [pct_pkg::TPS_W-1:0]  limit;
    logic [pct_pkg::TPS_W-1:0]  pre_inc;
    logic [GW+2:0]              gear_ext;
    logic [GW+2:0]              hours_ext;

    assign limit   = (i_ticks_per_second == '0) ? pct_pkg::TPS_W'(1) : i_ticks_per_second;
    assign pre_inc = r_prescale + pct_pkg::TPS_W'(1);

    always_comb begin
        n_prescale = r_prescale;
        n_secs     = r_secs;
        n_mins     = r_mins;
        n_hours    = r_hours;
        n_gear     = r_gear;
        n_run      = r_run;
        n_lock     = r_lock;
        n_armed    = r_armed;
        expired    = 1'b0;
        case (i_item.kind)
            pct_pkg::KIND_TICK: begin
                if (r_run) begin
                    n_prescale = pre_inc;
                    if (pre_inc >= limit) begin
                        n_prescale = '0;
                        if (r_secs != '0) begin
                            n_secs = r_secs - pct_pkg::TIME_W'(1);
                        end else if (r_mins != '0) begin
                            n_mins = r_mins - pct_pkg::TIME_W'(1);
                            n_secs = pct_pkg::SECS_MAX;
                        end else if (r_hours != '0) begin
                            n_hours = r_hours - GW'(1);
                            n_mins  = pct_pkg::SECS_MAX;
                            n_secs  = pct_pkg::SECS_MAX;
                        end else begin
                            n_run   = 1'b0;
                            n_gear  = '0;
                            expired = 1'b1;
                        end
                    end
                end
            end
            pct_pkg::KIND_KEY: begin
                if (!r_lock) begin
                    n_armed = 1'b1;
                    if (r_armed || r_gear == '0) begin
                        if (r_gear == TopGear) begin
                            n_gear  = '0;
                            n_secs  = '0;
                            n_mins  = '0;
                            n_hours = '0;
                            n_run   = 1'b0;
                            n_armed = 1'b0;
                        end else begin
                            n_gear = r_gear + GW'(1);
                            if (r_gear == '0) begin
                                n_mins  = pct_pkg::HALF_HOUR;
                                n_hours = '0;
                            end else begin
                                n_mins  = '0;
                                n_hours = r_gear;
                            end
                            n_secs     = '0;
                            n_prescale = '0;
                            n_run      = 1'b1;
                        end
                    end
                end
            end
            pct_pkg::KIND_STATUS: begin
                if (i_item.loads_idle) begin
                    if (!r_lock || r_run) begin
                        n_run   = 1'b0;
                        n_secs  = '0;
                        n_mins  = '0;
                        n_hours = '0;
                        n_gear  = '0;
                    end
                    n_lock = 1'b1;
                end else begin
                    n_lock = 1'b0;
                end
            end
            pct_pkg::KIND_OTHER: begin
                n_armed = 1'b0;
            end
            default: begin
                n_armed = r_armed;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale <= '0;
            r_secs     <= '0;
            r_mins     <= '0;
            r_hours    <= '0;
            r_gear     <= '0;
            r_run      <= 1'b0;
            r_lock     <= 1'b0;
            r_armed    <= 1'b0;
        end else if (i_fire) begin
            r_prescale <= n_prescale;
            r_secs     <= n_secs;
            r_mins     <= n_mins;
            r_hours    <= n_hours;
            r_gear     <= n_gear;
            r_run      <= n_run;
            r_lock     <= n_lock;
            r_armed    <= n_armed;
        end
    end

    assign gear_ext  = {3'b000, n_gear};
    assign hours_ext = {3'b000, n_hours};

    always_comb begin
        o_result.gear         = gear_ext[pct_pkg::OUT_GEAR_W-1:0];
        o_result.running      = n_run;
        o_result.hours_left   = hours_ext[pct_pkg::OUT_HRS_W-1:0];
        o_result.minutes_left = n_mins;
        o_result.seconds_left = n_secs;
        o_result.expired      = expired;
        o_result.locked       = n_lock;
    end

endmodule

/* rtl/core/pct_checker.sv */
// Port-level assertions of the preset countdown timer and their bind.
`include "preset_countdown_timer_top_defines.svh"

module pct_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          i_ready,
    input logic [pct_pkg::OUT_GEAR_W-1:0] i_gear,
    input logic                          i_running,
    input logic [pct_pkg::OUT_HRS_W-1:0]  i_hours,
    input logic [pct_pkg::TIME_W-1:0]     i_mins,
    input logic [pct_pkg::TIME_W-1:0]     i_secs,
    input logic                          i_expired,
    input logic                          i_locked
);

    `PCT_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_gear) && $stable(i_running) && $stable(i_mins) && $stable(i_secs) && $stable(i_expired))
    `PCT_ASSERT_NOW(a_expired_cleared, i_clk, i_rst_n, i_valid && i_expired, !i_running && i_gear == '0 && i_hours == '0 && i_mins == '0 && i_secs == '0)
    `PCT_ASSERT_NOW(a_locked_stopped, i_clk, i_rst_n, i_valid && i_locked, !i_running)
    `PCT_ASSERT_NOW(a_stopped_no_gear, i_clk, i_rst_n, i_valid && !i_running, i_gear == '0)

endmodule

bind preset_countdown_timer_top pct_checker u_pct_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_out.valid),
    .i_ready   (o_out.ready),
    .i_gear    (o_out.gear),
    .i_running (o_out.running),
    .i_hours   (o_out.hours_left),
    .i_mins    (o_out.minutes_left),
    .i_secs    (o_out.seconds_left),
    .i_expired (o_out.expired),
    .i_locked  (o_out.locked)
);

/* test/preset_countdown_timer_top_tb.sv */
// Testbench for the preset countdown timer: randomized items and handshake gaps,
// every readout checked against a local timer predictor.
`timescale 1ns / 1ps

module preset_countdown_timer_top_tb;

    localparam int TOP_GEAR        = pct_pkg::TOP_GEAR_DEFAULT;
    localparam int LONG_HOLD       = 60;
    localparam int LONG_HOLD_EVERY = 600;
    localparam int LONG_HOLD_AT    = 40;

    typedef struct {
        pct_pkg::t_item item;
        bit             drain;
    } t_timer_input;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [pct_pkg::TPS_W-1:0] i_cfg_wdata;

    pct_in_if  timer_in ();
    pct_out_if timer_out ();

    preset_countdown_timer_top #(
        .TOP_GEAR (TOP_GEAR)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (timer_in),
        .o_out       (timer_out)
    );

    // predictor state
    logic [pct_pkg::TPS_W-1:0]  m_tps;
    logic [7:0]                 m_presc;
    logic [pct_pkg::TIME_W-1:0] m_secs;
    logic [pct_pkg::TIME_W-1:0] m_mins;
    logic [7:0]                 m_hours;
    logic [7:0]                 m_gear;
    logic                       m_run;
    logic                       m_lock;
    logic                       m_armed;

    t_timer_input     timer_inputs_q[$];
    pct_pkg::t_result expected_readouts_q[$];

    int               max_gap;
    int               max_stall;
    int               send_gap;
    int               hold_left;
    int               n_items;
    int               n_results;
    int               n_expired;
    int               n_locked;
    int               n_settings;
    int               n_errors;
    pct_pkg::t_item   offered;
    pct_pkg::t_result want;

    function automatic pct_pkg::t_result next_readout(input pct_pkg::t_item it);
        pct_pkg::t_result r;
        int               limit;
        r.expired = 1'b0;
        case (it.kind)
            pct_pkg::KIND_TICK: begin
                if (m_run) begin
                    limit = (m_tps == 0) ? 1 : int'(m_tps);
                    m_presc = m_presc + 8'd1;
                    if (int'(m_presc) >= limit) begin
                        m_presc = '0;
                        if (m_secs != 0) begin
                            m_secs = m_secs - pct_pkg::TIME_W'(1);
                        end else if (m_mins != 0) begin
                            m_mins = m_mins - pct_pkg::TIME_W'(1);
                            m_secs = pct_pkg::SECS_MAX;
                        end else if (m_hours != 0) begin
                            m_hours = m_hours - 8'd1;
                            m_mins  = pct_pkg::SECS_MAX;
                            m_secs  = pct_pkg::SECS_MAX;
                        end else begin
                            m_run     = 1'b0;
                            m_gear    = '0;
                            r.expired = 1'b1;
                        end
                    end
                end
            end
            pct_pkg::KIND_KEY: begin
                if (!m_lock) begin
                    if (m_armed || m_gear == 0) begin
                        m_run  = 1'b0;
                        m_gear = m_gear + 8'd1;
                        if (m_gear > TOP_GEAR) begin
                            m_gear  = '0;
                            m_secs  = '0;
                            m_mins  = '0;
                            m_hours = '0;
                        end else begin
                            if (m_gear == 1) begin
                                m_mins  = pct_pkg::HALF_HOUR;
                                m_hours = '0;
                            end else begin
                                m_hours = m_gear - 8'd1;
                                m_mins  = '0;
                            end
                            m_secs  = '0;
                            m_presc = '0;
                            m_run   = 1'b1;
                        end
                    end
                    // wrap past the top gear leaves the key disarmed
                    m_armed = (m_gear != 0);
                end
            end
            pct_pkg::KIND_STATUS: begin
                if (it.loads_idle) begin
                    if (!m_lock || m_run) begin
                        m_run   = 1'b0;
                        m_secs  = '0;
                        m_mins  = '0;
                        m_hours = '0;
                        m_gear  = '0;
                    end
                    m_lock = 1'b1;
                end else begin
                    m_lock = 1'b0;
                end
            end
            default: m_armed = 1'b0;
        endcase
        r.gear         = m_gear[pct_pkg::OUT_GEAR_W-1:0];
        r.running      = m_run;
        r.hours_left   = m_hours[pct_pkg::OUT_HRS_W-1:0];
        r.minutes_left = m_mins;
        r.seconds_left = m_secs;
        r.locked       = m_lock;
        return r;
    endfunction

    task automatic queue_input(input pct_pkg::t_kind k, input logic idle,
                               input bit drain = 1'b0);
        t_timer_input e;
        e.item.kind       = k;
        e.item.loads_idle = idle;
        e.drain           = drain;
        timer_inputs_q.push_back(e);
    endtask

    task automatic queue_ticks(input int count);
        repeat (count) queue_input(pct_pkg::KIND_TICK, 1'($urandom_range(0, 1)));
    endtask

    // mostly key presses followed by tick bursts, with loose items mixed in
    task automatic queue_random(input int count);
        int added;
        int keys;
        int ticks;
        added = 0;
        while (added < count) begin
            if ($urandom_range(0, 9) < 6) begin
                keys  = $urandom_range(1, 3);
                ticks = $urandom_range(1, 25);
                repeat (keys) queue_input(pct_pkg::KIND_KEY, 1'($urandom_range(0, 1)));
                queue_ticks(ticks);
                added += keys + ticks;
            end else begin
                queue_input(pct_pkg::t_kind'($urandom_range(0, 3)),
                            1'($urandom_range(0, 1)));
                added++;
            end
        end
    endtask

    task automatic wait_quiet();
        while (timer_inputs_q.size() != 0 || timer_in.valid ||
               expected_readouts_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_tps(input logic [pct_pkg::TPS_W-1:0] value);
        wait_quiet();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        m_tps = value;
        n_settings++;
    endtask

    task automatic compare_field(input string what, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, what, exp_val, act_val);
            n_errors++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d readouts still expected", expected_readouts_q.size());
        $display("TEST FAILED");
        $finish;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            timer_in.valid      <= 1'b0;
            timer_in.kind       <= pct_pkg::KIND_TICK;
            timer_in.loads_idle <= 1'b0;
            send_gap = 0;
            n_items  = 0;
            m_presc  = '0;
            m_secs   = '0;
            m_mins   = '0;
            m_hours  = '0;
            m_gear   = '0;
            m_run    = 1'b0;
            m_lock   = 1'b0;
            m_armed  = 1'b0;
        end else begin
            if (timer_in.valid && timer_in.ready) begin
                expected_readouts_q.push_back(next_readout(offered));
                n_items++;
                send_gap = $urandom_range(0, max_gap);
            end
            if (!timer_in.valid || timer_in.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    timer_in.valid <= 1'b0;
                end else if (timer_inputs_q.size() != 0 &&
                             !(timer_inputs_q[0].drain && expected_readouts_q.size() != 0)) begin
                    offered = timer_inputs_q[0].item;
                    void'(timer_inputs_q.pop_front());
                    timer_in.valid      <= 1'b1;
                    timer_in.kind       <= offered.kind;
                    timer_in.loads_idle <= offered.loads_idle;
                end else begin
                    timer_in.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            timer_out.ready <= 1'b0;
            hold_left = 0;
            n_results = 0;
            n_expired = 0;
            n_locked  = 0;
            n_errors  = 0;
        end else begin
            if (timer_out.valid && timer_out.ready) begin
                n_results++;
                if (expected_readouts_q.size() == 0) begin
                    $display("%0t: unexpected readout, expected none, actual gear %0d",
                             $time, timer_out.gear);
                    n_errors++;
                end else begin
                    want = expected_readouts_q.pop_front();
                    compare_field("gear", want.gear, timer_out.gear);
                    compare_field("running", want.running, timer_out.running);
                    compare_field("hours_left", want.hours_left, timer_out.hours_left);
                    compare_field("minutes_left", want.minutes_left, timer_out.minutes_left);
                    compare_field("seconds_left", want.seconds_left, timer_out.seconds_left);
                    compare_field("expired", want.expired, timer_out.expired);
                    compare_field("locked", want.locked, timer_out.locked);
                    if (want.expired) n_expired++;
                    if (want.locked) n_locked++;
                end
                hold_left = (n_results % LONG_HOLD_EVERY == LONG_HOLD_AT) ?
                            LONG_HOLD : $urandom_range(0, max_stall);
            end else if (hold_left > 0) begin
                hold_left--;
            end
            timer_out.ready <= (hold_left == 0);
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        m_tps       = pct_pkg::TICKS_RESET;
        max_gap     = 19;
        max_stall   = 19;
        n_settings  = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk through the gears, arming, locking and disarming
        queue_input(pct_pkg::KIND_TICK, 1'b0);
        queue_input(pct_pkg::KIND_OTHER, 1'b0);
        queue_input(pct_pkg::KIND_KEY, 1'b0);
        queue_input(pct_pkg::KIND_TICK, 1'b1);
        queue_input(pct_pkg::KIND_KEY, 1'b0);
        queue_input(pct_pkg::KIND_OTHER, 1'b0);
        queue_input(pct_pkg::KIND_KEY, 1'b1);
        repeat (5) queue_input(pct_pkg::KIND_KEY, 1'b0);
        queue_input(pct_pkg::KIND_KEY, 1'b0);
        queue_input(pct_pkg::KIND_KEY, 1'b1);
        queue_input(pct_pkg::KIND_STATUS, 1'b0);
        queue_input(pct_pkg::KIND_STATUS, 1'b1);
        queue_input(pct_pkg::KIND_KEY, 1'b0);
        queue_input(pct_pkg::KIND_STATUS, 1'b1);
        queue_input(pct_pkg::KIND_TICK, 1'b0);
        queue_input(pct_pkg::KIND_STATUS, 1'b0);
        queue_input(pct_pkg::KIND_KEY, 1'b0);
        queue_input(pct_pkg::KIND_OTHER, 1'b1);
        queue_input(pct_pkg::KIND_KEY, 1'b1);
        queue_input(pct_pkg::KIND_TICK, 1'b0);
        queue_input(pct_pkg::KIND_KEY, 1'b0);

        // zero rate acts as one: minute borrow, then hour borrow
        set_tps('0);
        max_gap   = 3;
        max_stall = 3;
        queue_input(pct_pkg::KIND_TICK, 1'b0);
        queue_input(pct_pkg::KIND_STATUS, 1'b1);
        queue_input(pct_pkg::KIND_STATUS, 1'b0);
        queue_input(pct_pkg::KIND_KEY, 1'b0);
        queue_ticks(3);
        queue_input(pct_pkg::KIND_KEY, 1'b0);
        queue_ticks(40);

        // one step after the prescaler fills
        set_tps(8'd60);
        queue_input(pct_pkg::KIND_KEY, 1'b0);
        queue_ticks(62);

        set_tps(8'd200);
        max_gap   = 19;
        max_stall = 19;
        queue_random(30);
        queue_input(pct_pkg::KIND_TICK, 1'b0, 1'b1);
        queue_random(30);

        // lower the rate below the running count
        set_tps(8'd3);
        max_gap   = 0;
        max_stall = 0;
        queue_random(50);

        set_tps(8'd1);
        max_gap   = 19;
        max_stall = 0;
        queue_random(30);
        queue_input(pct_pkg::KIND_KEY, 1'b1, 1'b1);
        queue_random(30);

        set_tps(8'd2);
        max_gap   = 0;
        max_stall = 19;
        queue_random(50);

        set_tps(8'($urandom_range(1, 255)));
        max_gap   = 19;
        max_stall = 19;
        queue_random(50);

        wait_quiet();
        repeat (5) @(posedge i_clk);

        $display("Sent %0d items over %0d rate settings and checked %0d readouts;",
                 n_items, n_settings, n_results);
        $display("%0d countdowns expired, %0d readouts showed the keys locked out.",
                 n_expired, n_locked);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
